// ----- rtl/lsn_ordered_item_list_unit_defines.svh -----
// Assertion macros used by the ordered item list unit.
`ifndef LSN_ORDERED_ITEM_LIST_UNIT_DEFINES_SVH
`define LSN_ORDERED_ITEM_LIST_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define OIL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OIL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OIL_ASSERT(label, clk, rst_n, prop, msg)
`define OIL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/lsnol_pkg.sv -----
package lsnol_pkg;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int ID_W = 6;
	localparam int ID_COUNT = 64;
	localparam int LSN_W = 64;
	localparam int GEN_W = 32;

	typedef enum logic [2:0] {
		OP_UPDATE = 3'd0,
		OP_DELETE = 3'd1,
		OP_TAIL   = 3'd2,
		OP_FIRST  = 3'd3,
		OP_NEXT   = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]             op;
		logic [ID_W-1:0]        item_id;
		logic signed [LSN_W-1:0] new_lsn;
		logic [GEN_W-1:0]       caller_generation;
	} in_beat_t;

	typedef struct packed {
		logic                    found;
		logic [ID_W-1:0]         result_item;
		logic signed [LSN_W-1:0] result_lsn;
		logic [GEN_W-1:0]        generation;
		logic                    error;
	} out_beat_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                    rm_en;     // drop the entry holding rm_id
		logic [ID_W-1:0]         rm_id;
		logic                    ins_en;    // insert ins_id with ins_lsn
		logic [ID_W-1:0]         ins_id;
		logic signed [LSN_W-1:0] ins_lsn;
	} cell_cmd_t;

	// What one cell hands to its upper neighbor.
	typedef struct packed {
		logic                    valid;
		logic [ID_W-1:0]         id;
		logic signed [LSN_W-1:0] lsn;
		logic                    gone;      // rm_id seen at or below
		logic                    le;        // every entry at or below is valid with lsn <= ins_lsn
	} cell_link_t;
endpackage

// ----- rtl/lsn_ordered_item_list_unit.sv -----
// Ordered item list: holds up to MAX_ITEMS item ids sorted by ascending
// signed 64-bit sequence number, equal numbers in insertion order, in a
// chain of cells that each hold one list slot. Every operation first looks
// the item up in the chain and decides, then the whole chain removes and
// reinserts in a single step (or the head is read). One operation is in
// flight at a time; a finished result sits in an output register and a new
// beat is taken as soon as it is delivered or while it is being taken. Next
// finds its successor by scanning the mirrored slot contents in the same
// step.
`include "lsn_ordered_item_list_unit_defines.svh"
module lsn_ordered_item_list_unit
	import lsnol_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                  state_q;
	in_beat_t                req_s1;
	logic [CNT_W-1:0]        count_q;
	logic [GEN_W-1:0]        gen_q;
	logic                    out_valid_q;
	out_beat_t               out_q;
	out_beat_t               out_d;
	cell_cmd_t               cmd_q;
	cell_cmd_t               cmd_d;
	logic                    ok_q;
	logic                    ok_d;
	logic                    accept;
	logic                    step;
	logic                    present_id;
	cell_link_t [MAX_ITEMS:0]      chain;
	cell_link_t [MAX_ITEMS-1:0]    raw;
	cell_link_t [MAX_ITEMS-1:0]    above;
	logic [MAX_ITEMS-1:0]          nv;
	logic [MAX_ITEMS-1:0][ID_W-1:0]  nid;
	logic [MAX_ITEMS-1:0][LSN_W-1:0] nlsn;
	logic                    nxt_found;
	logic [ID_W-1:0]         nxt_id;
	logic signed [LSN_W-1:0] nxt_lsn;
	logic                    full;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign step = (state_q == ST_EXEC);
	assign full = (count_q == CNT_W'(MAX_ITEMS));

	// An item is present when some occupied slot of the chain holds its id.
	always_comb begin
		present_id = 1'b0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (raw[i].valid && raw[i].id == in_data.item_id) present_id = 1'b1;
		end
	end

	// Sequencer: lookup/decide, then chain step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decide the chain command from the lookup.
	always_comb begin
		cmd_d = '0;
		cmd_d.rm_id = in_data.item_id;
		cmd_d.ins_id = in_data.item_id;
		cmd_d.ins_lsn = in_data.new_lsn;
		ok_d = present_id;
		if (in_data.op == OP_UPDATE && (present_id || !full)) begin
			cmd_d.rm_en = present_id;
			cmd_d.ins_en = 1'b1;
			ok_d = 1'b1;
		end else if (in_data.op == OP_DELETE && present_id) begin
			cmd_d.rm_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			ok_q <= 1'b0;
		end else if (accept) begin
			cmd_q <= cmd_d;
			ok_q <= ok_d;
		end else if (step) begin
			cmd_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_s1 <= in_data;
	end

	// Chain of cells; slot 0 is the head.
	assign chain[0].valid = 1'b0;
	assign chain[0].id = '0;
	assign chain[0].lsn = '0;
	assign chain[0].gone = 1'b0;
	assign chain[0].le = 1'b1;

	genvar g;
	generate
		for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
			if (g == MAX_ITEMS - 1) begin : g_top
				assign above[g] = '0;
			end else begin : g_mid
				assign above[g] = raw[g+1];
			end
			lsnol_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (step),
				.cmd    (cmd_q),
				.below  (chain[g]),
				.above  (above[g]),
				.link   (chain[g+1])
			);
			// Mirror of what the cell loads this step.
			always_comb begin
				if (cmd_q.ins_en && chain[g].le && !(chain[g+1].valid &&
						chain[g+1].lsn <= cmd_q.ins_lsn)) begin
					nv[g] = 1'b1;
					nid[g] = cmd_q.ins_id;
					nlsn[g] = cmd_q.ins_lsn;
				end else if (cmd_q.ins_en && !chain[g].le) begin
					nv[g] = chain[g].valid;
					nid[g] = chain[g].id;
					nlsn[g] = chain[g].lsn;
				end else begin
					nv[g] = chain[g+1].valid;
					nid[g] = chain[g+1].id;
					nlsn[g] = chain[g+1].lsn;
				end
			end
		end
	endgenerate

	lsnol_cell_tap #(.MAX_ITEMS(MAX_ITEMS)) u_tap (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.next_valid (nv),
		.next_id    (nid),
		.next_lsn   (nlsn),
		.raw        (raw)
	);

	// Successor: the slot after the one holding the request's id.
	always_comb begin
		nxt_found = 1'b0;
		nxt_id = '0;
		nxt_lsn = '0;
		for (int i = 0; i + 1 < MAX_ITEMS; i++) begin
			if (raw[i].valid && raw[i].id == req_s1.item_id && raw[i+1].valid) begin
				nxt_found = 1'b1;
				nxt_id = raw[i+1].id;
				nxt_lsn = raw[i+1].lsn;
			end
		end
	end

	// Count and generation updated in the chain step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			gen_q <= '0;
		end else if (step && ok_q) begin
			if (cmd_q.ins_en) begin
				gen_q <= gen_q + 1'b1;
				if (!cmd_q.rm_en) count_q <= count_q + 1'b1;
			end else if (cmd_q.rm_en) begin
				gen_q <= gen_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result contents for the operation in the chain step.
	always_comb begin
		out_d = '0;
		out_d.generation = gen_q;
		unique case (req_s1.op)
			OP_UPDATE: begin
				out_d.error = !ok_q;
				if (ok_q) out_d.generation = gen_q + 1'b1;
			end
			OP_DELETE: begin
				out_d.error = !ok_q;
				if (ok_q) out_d.generation = gen_q + 1'b1;
			end
			OP_TAIL: begin
				if (raw[0].valid) begin
					out_d.found = 1'b1;
					out_d.result_lsn = raw[0].lsn;
				end
			end
			OP_FIRST: begin
				if (raw[0].valid) begin
					out_d.found = 1'b1;
					out_d.result_item = raw[0].id;
					out_d.result_lsn = raw[0].lsn;
				end
			end
			OP_NEXT: begin
				if (!ok_q) begin
					out_d.error = 1'b1;
				end else if (req_s1.caller_generation != gen_q) begin
					if (raw[0].valid) begin
						out_d.found = 1'b1;
						out_d.result_item = raw[0].id;
						out_d.result_lsn = raw[0].lsn;
					end
				end else if (nxt_found) begin
					out_d.found = 1'b1;
					out_d.result_item = nxt_id;
					out_d.result_lsn = nxt_lsn;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (step) out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`OIL_ASSERT(a_one_hot_state, clk, arst_n, $onehot(state_q), "state not one-hot")
	`OIL_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_ITEMS), "count overflow")
	`OIL_ASSERT(a_no_accept_busy, clk, arst_n, step |-> !accept, "accept while busy")
	`OIL_ASSERT(a_result_after_step, clk, arst_n, step |=> out_valid_q, "result missing")
endmodule

// ----- rtl/lsnol_cell.sv -----
// One slot of the sorted chain. The list is packed from slot 0 upward.
// In a single cycle a cell may drop a removed entry (shifting down from
// its upper neighbor) and then place the new entry (shifting up from its
// lower neighbor); the command is registered in the cycle before so both fit.
module lsnol_cell
	import lsnol_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cell_cmd_t  cmd,
	input  cell_link_t below,     // neighbor toward the head
	input  cell_link_t above,     // neighbor toward the tail, raw contents
	output cell_link_t link
);
	logic                    valid_q;
	logic [ID_W-1:0]         id_q;
	logic signed [LSN_W-1:0] lsn_q;
	logic                    hit;
	logic                    gone_here;
	// Contents after removal, for this cell and for the one above.
	logic                    r_valid;
	logic [ID_W-1:0]         r_id;
	logic signed [LSN_W-1:0] r_lsn;
	logic                    le_here;
	logic                    place;

	assign hit = cmd.rm_en && valid_q && (id_q == cmd.rm_id);
	assign gone_here = below.gone || hit;

	// Removal view: once the removed entry is at or below, take the upper one.
	always_comb begin
		if (gone_here) begin
			r_valid = above.valid;
			r_id = above.id;
			r_lsn = above.lsn;
		end else begin
			r_valid = valid_q;
			r_id = id_q;
			r_lsn = lsn_q;
		end
	end

	assign le_here = r_valid && (r_lsn <= cmd.ins_lsn);
	assign place = cmd.ins_en && below.le && !le_here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			if (place) begin
				valid_q <= 1'b1;
			end else if (cmd.ins_en && !below.le) begin
				valid_q <= below.valid;
			end else begin
				valid_q <= r_valid;
			end
		end
	end

	// Payload: the new entry, the shifted lower neighbor, or the kept one.
	always_ff @(posedge clk) begin
		if (step) begin
			if (place) begin
				id_q <= cmd.ins_id;
				lsn_q <= cmd.ins_lsn;
			end else if (cmd.ins_en && !below.le) begin
				id_q <= below.id;
				lsn_q <= below.lsn;
			end else begin
				id_q <= r_id;
				lsn_q <= r_lsn;
			end
		end
	end

	// Toward the upper neighbor: post-removal contents plus chain flags.
	assign link.valid = r_valid;
	assign link.id = r_id;
	assign link.lsn = r_lsn;
	assign link.gone = gone_here;
	assign link.le = below.le && le_here;

	// Raw contents for the lower neighbor come through a separate path.
endmodule

// ----- rtl/lsnol_cell_tap.sv -----
// Gives the raw stored contents of each cell to the cell below it and to
// the unit's lookups, from its own copy rather than from the post-removal links.
// Kept as a registered mirror: raw contents equal what the cell
// loaded last, tracked here from the same inputs.
module lsnol_cell_tap
	import lsnol_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [MAX_ITEMS-1:0]  next_valid,
	input  logic [MAX_ITEMS-1:0][ID_W-1:0] next_id,
	input  logic [MAX_ITEMS-1:0][LSN_W-1:0] next_lsn,
	output cell_link_t [MAX_ITEMS-1:0] raw
);
	logic [MAX_ITEMS-1:0]            valid_q;
	logic [MAX_ITEMS-1:0][ID_W-1:0]  id_q;
	logic [MAX_ITEMS-1:0][LSN_W-1:0] lsn_q;

	// Shadow copy of each cell's contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (step) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			id_q <= next_id;
			lsn_q <= next_lsn;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			raw[i].valid = valid_q[i];
			raw[i].id = id_q[i];
			raw[i].lsn = lsn_q[i];
			raw[i].gone = 1'b0;
			raw[i].le = 1'b0;
		end
	end
endmodule
